>>> rtl/etcf_pkg.sv
// Package for the ESC telemetry to CRSF framer: control word type, microcode
// table and the CRC-8 (poly 0xD5) byte update. No dependencies.
package etcf_pkg;

  localparam int unsigned StepW     = 5;
  localparam int unsigned StoreDepth = 14;
  localparam int unsigned StoreIdxW = 4;
  localparam int unsigned PosW      = 5;
  localparam logic [PosW-1:0] FirstPos = 5'd3;
  localparam logic [PosW-1:0] LastPos  = 5'd16;
  localparam logic [PosW-1:0] PosMax   = 5'd31;
  localparam logic [StepW-1:0] LastStep = 5'd27;

  localparam logic [7:0] CrsfSync    = 8'hC8;
  localparam logic [7:0] TypeBattery = 8'h08;
  localparam logic [7:0] TypeRpm     = 8'h0C;
  localparam logic [7:0] TypeTemp    = 8'h0D;
  localparam logic [7:0] CrcPoly     = 8'hD5;

  // Byte source of one step
  typedef enum logic [2:0] {
    SRC_CONST,
    SRC_STORE,
    SRC_TEMP_HI,
    SRC_TEMP_LO,
    SRC_CRC
  } src_t;

  // CRC register action of one step
  typedef enum logic [1:0] {
    CRC_HOLD,
    CRC_CLEAR,
    CRC_ACC
  } crc_op_t;

  typedef struct packed {
    logic    wait_eob;   // idle step: take input, jump to step 1 on end of burst
    src_t    src;
    logic [7:0] lit;     // constant byte, or store index in the low bits
    crc_op_t crc_op;
    logic    frame_end;
    logic    last;       // final byte: jump back to the idle step
  } ctl_t;

  function automatic ctl_t mk(input src_t s, input logic [7:0] l, input crc_op_t c,
                              input logic fe, input logic la);
    ctl_t w;
    w.wait_eob  = 1'b0;
    w.src       = s;
    w.lit       = l;
    w.crc_op    = c;
    w.frame_end = fe;
    w.last      = la;
    return w;
  endfunction

  function automatic ctl_t ucode(input logic [StepW-1:0] step);
    ctl_t w;
    w = mk(SRC_CONST, 8'h00, CRC_HOLD, 1'b0, 1'b0);
    w.wait_eob = 1'b1;
    case (step)
      // battery frame
      5'd1:  w = mk(SRC_CONST, CrsfSync,    CRC_CLEAR, 1'b0, 1'b0);
      5'd2:  w = mk(SRC_CONST, 8'd10,       CRC_HOLD,  1'b0, 1'b0);
      5'd3:  w = mk(SRC_CONST, TypeBattery, CRC_ACC,   1'b0, 1'b0);
      5'd4:  w = mk(SRC_STORE, 8'd0,        CRC_ACC,   1'b0, 1'b0);
      5'd5:  w = mk(SRC_STORE, 8'd1,        CRC_ACC,   1'b0, 1'b0);
      5'd6:  w = mk(SRC_STORE, 8'd2,        CRC_ACC,   1'b0, 1'b0);
      5'd7:  w = mk(SRC_STORE, 8'd3,        CRC_ACC,   1'b0, 1'b0);
      5'd8:  w = mk(SRC_CONST, 8'h00,       CRC_ACC,   1'b0, 1'b0);
      5'd9:  w = mk(SRC_STORE, 8'd12,       CRC_ACC,   1'b0, 1'b0);
      5'd10: w = mk(SRC_STORE, 8'd13,       CRC_ACC,   1'b0, 1'b0);
      5'd11: w = mk(SRC_CONST, 8'h00,       CRC_ACC,   1'b0, 1'b0);
      5'd12: w = mk(SRC_CRC,   8'h00,       CRC_HOLD,  1'b1, 1'b0);
      // rpm frame
      5'd13: w = mk(SRC_CONST, CrsfSync,    CRC_CLEAR, 1'b0, 1'b0);
      5'd14: w = mk(SRC_CONST, 8'd6,        CRC_HOLD,  1'b0, 1'b0);
      5'd15: w = mk(SRC_CONST, TypeRpm,     CRC_ACC,   1'b0, 1'b0);
      5'd16: w = mk(SRC_CONST, 8'h00,       CRC_ACC,   1'b0, 1'b0);
      5'd17: w = mk(SRC_CONST, 8'h00,       CRC_ACC,   1'b0, 1'b0);
      5'd18: w = mk(SRC_STORE, 8'd5,        CRC_ACC,   1'b0, 1'b0);
      5'd19: w = mk(SRC_STORE, 8'd6,        CRC_ACC,   1'b0, 1'b0);
      5'd20: w = mk(SRC_CRC,   8'h00,       CRC_HOLD,  1'b1, 1'b0);
      // temperature frame
      5'd21: w = mk(SRC_CONST, CrsfSync,    CRC_CLEAR, 1'b0, 1'b0);
      5'd22: w = mk(SRC_CONST, 8'd5,        CRC_HOLD,  1'b0, 1'b0);
      5'd23: w = mk(SRC_CONST, TypeTemp,    CRC_ACC,   1'b0, 1'b0);
      5'd24: w = mk(SRC_CONST, 8'h00,       CRC_ACC,   1'b0, 1'b0);
      5'd25: w = mk(SRC_TEMP_HI, 8'h00,     CRC_ACC,   1'b0, 1'b0);
      5'd26: w = mk(SRC_TEMP_LO, 8'h00,     CRC_ACC,   1'b0, 1'b0);
      5'd27: w = mk(SRC_CRC,   8'h00,       CRC_HOLD,  1'b1, 1'b1);
      default: ;
    endcase
    return w;
  endfunction

  // One byte into the CRC-8, MSB first
  function automatic logic [7:0] crc8_upd(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] c;
    c = crc ^ d;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

>>> rtl/esc_telemetry_to_crsf_framer.sv
// Top level of the ESC telemetry to CRSF framer: capture store, microcoded
// sequencer and output register. Depends on etcf_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall): one telemetry byte per transaction,
//   in_end_of_burst high on the last byte of a burst. Bytes at burst
//   positions 3..16 are kept in a 14-entry store; others are dropped.
//   Output channel (out_valid / out_stall): one CRSF byte per transaction.
//   A flagged byte starts a run of 27 bytes: battery frame (12), rpm frame
//   (8), temperature frame (7). out_frame_end marks each CRC byte and
//   out_last the final CRC byte of the run.
// Timing:
//   Ordinary bytes are taken without stall. A flagged byte moves the
//   sequencer to step 1, whose byte is then loaded into the output register,
//   then one byte per cycle while the receiver does not stall. The step
//   counter of the microcode program gives one control word per output byte.
//   in_stall is high for the whole run; it drops at the edge that loads the
//   final byte into the output register, so the next byte can then be taken.
// Reset (rst_n low, synchronous): position counter, store and sequencer
//   cleared, output register empty.
// Stall: the output register holds its byte; the sequencer does not advance.
module esc_telemetry_to_crsf_framer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       in_end_of_burst,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_tx_byte,
  output logic       out_frame_end,
  output logic       out_last
);

  logic [etcf_pkg::StepW-1:0] step_r, step_nxt;
  logic [etcf_pkg::PosW-1:0]  pos_r, pos_nxt;
  logic [7:0]                 store_r [etcf_pkg::StoreDepth];
  logic [7:0]                 crc_r, crc_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [7:0]                 out_byte_r;
  logic                       out_fe_r, out_last_r;

  etcf_pkg::ctl_t ctl;
  logic           in_take;
  logic           emit;
  logic [7:0]     byte_sel;
  logic [11:0]    temp;
  logic           pos_in_store;
  logic [etcf_pkg::PosW-1:0] widx;

  assign ctl      = etcf_pkg::ucode(step_r);
  assign in_stall = !ctl.wait_eob;
  assign in_take  = in_valid && ctl.wait_eob;
  // Load a byte when the output register is free or being emptied
  assign emit     = !ctl.wait_eob && (!out_valid_r || !out_stall);

  // v10 * 10 as 8x + 2x
  assign temp = {1'b0, store_r[7], 3'b000} + {3'b000, store_r[7], 1'b0};

  assign pos_in_store = (pos_r >= etcf_pkg::FirstPos) && (pos_r <= etcf_pkg::LastPos);
  assign widx         = pos_r - etcf_pkg::FirstPos;

  always_comb begin
    byte_sel = ctl.lit;
    case (ctl.src)
      etcf_pkg::SRC_CONST:   byte_sel = ctl.lit;
      etcf_pkg::SRC_STORE:   byte_sel = store_r[ctl.lit[etcf_pkg::StoreIdxW-1:0]];
      etcf_pkg::SRC_TEMP_HI: byte_sel = {4'h0, temp[11:8]};
      etcf_pkg::SRC_TEMP_LO: byte_sel = temp[7:0];
      etcf_pkg::SRC_CRC:     byte_sel = crc_r;
      default:               byte_sel = ctl.lit;
    endcase
  end

  // Sequencer: wait on the idle step, then advance one step per emitted byte
  always_comb begin
    step_nxt = step_r;
    if (in_take && in_end_of_burst) begin
      step_nxt = 5'd1;
    end else if (emit) begin
      step_nxt = ctl.last ? '0 : step_r + 5'd1;
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (in_take) begin
      if (in_end_of_burst) begin
        pos_nxt = '0;
      end else if (pos_r != etcf_pkg::PosMax) begin
        pos_nxt = pos_r + 5'd1;
      end
    end
  end

  always_comb begin
    crc_nxt = crc_r;
    if (emit) begin
      case (ctl.crc_op)
        etcf_pkg::CRC_CLEAR: crc_nxt = '0;
        etcf_pkg::CRC_ACC:   crc_nxt = etcf_pkg::crc8_upd(crc_r, byte_sel);
        default:             crc_nxt = crc_r;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      pos_r       <= '0;
      crc_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < etcf_pkg::StoreDepth; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      step_r      <= step_nxt;
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_take && pos_in_store) begin
        store_r[widx[etcf_pkg::StoreIdxW-1:0]] <= in_rx_byte;
      end
    end
  end

  // Output payload, no reset
  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= byte_sel;
      out_fe_r   <= ctl.frame_end;
      out_last_r <= ctl.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_tx_byte   = out_byte_r;
  assign out_frame_end = out_fe_r;
  assign out_last      = out_last_r;

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= etcf_pkg::LastStep)
    else $error("step counter past end of program");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> out_frame_end)
    else $error("last byte not a frame end");

  a_eob_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_end_of_burst) |=> (step_r == 5'd1 && in_stall))
    else $error("end of burst did not start the run");

  a_no_input_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r != '0) |-> in_stall)
    else $error("input taken during a run");
`endif

endmodule

>>> tb/testbench.sv
// Self-checking testbench for esc_telemetry_to_crsf_framer: random telemetry bursts in,
// checked CRSF battery/rpm/temperature frame bytes out. Depends on etcf_pkg and the RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 300000;
  localparam int HoldOffCycles = 300;
  localparam int DrainCycles = 40;

  typedef struct {
    logic [7:0] rx;
    logic       eob;
  } telem_item_t;

  typedef struct {
    logic [7:0] data;
    logic       frame_end;
    logic       last;
  } crsf_byte_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       in_end_of_burst = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_tx_byte;
  logic       out_frame_end;
  logic       out_last;

  // Pending input transactions and the CRSF bytes they must produce, oldest first.
  telem_item_t telem_q[$];
  crsf_byte_t  crsf_q[$];

  // Knobs set at the falling edge; hold_off comes from the hold-off timer.
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_off = 1'b0;
  bit hold_go = 1'b0;
  int hold_cnt = 0;

  int mismatches = 0;
  int cycle_cnt = 0;

  // Shadow copy of the framer: burst position and captured bytes 3..16.
  logic [etcf_pkg::PosW-1:0] burst_pos = '0;
  logic [7:0]      telem_store [etcf_pkg::StoreDepth];
  logic [7:0]      frame_buf [12];

  telem_item_t next_item;
  crsf_byte_t  want;

  esc_telemetry_to_crsf_framer u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .in_end_of_burst(in_end_of_burst),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_tx_byte    (out_tx_byte),
    .out_frame_end  (out_frame_end),
    .out_last       (out_last)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Seal the frame held in frame_buf[0 .. len-1]: compute the CRC-8 (poly 0xD5, init 0)
  // over type and payload, skipping sync and length, then queue every byte.
  function automatic void queue_frame(input int len, input bit run_end);
    logic [7:0] crc;
    crc = 8'h00;
    for (int i = 2; i < len - 1; i++) begin
      crc = crc ^ frame_buf[i];
      for (int b = 0; b < 8; b++) begin
        crc = crc[7] ? ({crc[6:0], 1'b0} ^ etcf_pkg::CrcPoly) : {crc[6:0], 1'b0};
      end
    end
    frame_buf[len-1] = crc;
    for (int i = 0; i < len; i++) begin
      crsf_q.push_back('{data: frame_buf[i], frame_end: (i == len - 1),
                         last: run_end && (i == len - 1)});
    end
  endfunction

  // Advance the shadow framer by one accepted telemetry byte; on the burst-ending
  // byte queue the battery, rpm and temperature frames.
  function automatic void frame_telemetry(input logic [7:0] rx, input logic eob);
    logic [15:0] temp_x10;
    if (burst_pos >= etcf_pkg::FirstPos && burst_pos <= etcf_pkg::LastPos)
      telem_store[burst_pos - etcf_pkg::FirstPos] = rx;
    if (burst_pos < etcf_pkg::PosMax) burst_pos = burst_pos + 1'b1;
    if (eob) begin
      burst_pos = '0;
      // battery: voltage, current, 24-bit capacity (high byte 0), remaining 0
      frame_buf[0] = etcf_pkg::CrsfSync; frame_buf[1] = 8'd10;
      frame_buf[2] = etcf_pkg::TypeBattery;
      frame_buf[3] = telem_store[0]; frame_buf[4] = telem_store[1];
      frame_buf[5] = telem_store[2]; frame_buf[6] = telem_store[3];
      frame_buf[7] = 8'h00;          frame_buf[8] = telem_store[12];
      frame_buf[9] = telem_store[13]; frame_buf[10] = 8'h00;
      queue_frame(12, 1'b0);
      // rpm: motor id 0, 24-bit rpm with high byte 0
      frame_buf[0] = etcf_pkg::CrsfSync; frame_buf[1] = 8'd6;
      frame_buf[2] = etcf_pkg::TypeRpm;
      frame_buf[3] = 8'h00;          frame_buf[4] = 8'h00;
      frame_buf[5] = telem_store[5]; frame_buf[6] = telem_store[6];
      queue_frame(8, 1'b0);
      // temperature: source 0, captured degrees times ten, big endian
      temp_x10 = {8'h00, telem_store[7]} * 16'd10;
      frame_buf[0] = etcf_pkg::CrsfSync; frame_buf[1] = 8'd5;
      frame_buf[2] = etcf_pkg::TypeTemp;
      frame_buf[3] = 8'h00;          frame_buf[4] = temp_x10[15:8];
      frame_buf[5] = temp_x10[7:0];
      queue_frame(7, 1'b1);
    end
  endfunction

  function automatic void flag_mismatch(input string what, input crsf_byte_t exp_b,
                                        input crsf_byte_t got_b);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s) at cycle %0d: expected %02h/%0b/%0b got %02h/%0b/%0b", what,
               cycle_cnt, exp_b.data, exp_b.frame_end, exp_b.last,
               got_b.data, got_b.frame_end, got_b.last);
  endfunction

  // Append random bursts until n_items bytes are queued. Most bursts are full length
  // (positions 0..16); the rest are short, or longer and some saturate the position.
  function automatic void add_bursts(input int n_items);
    int added;
    int len;
    int pick;
    added = 0;
    while (added < n_items) begin
      pick = $urandom_range(99);
      if (pick < 70) len = 17;
      else if (pick < 85) len = $urandom_range(16, 1);
      else len = $urandom_range(40, 18);
      for (int i = 0; i < len; i++)
        telem_q.push_back('{rx: 8'($urandom), eob: (i == len - 1)});
      added += len;
    end
  endfunction

  // Driver: retire the accepted transaction into the predictor, then hold a stalled
  // item or offer the next one unless this cycle idles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) frame_telemetry(in_rx_byte, in_end_of_burst);
      if (!in_valid || !in_stall) begin
        if (telem_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          next_item = telem_q.pop_front();
          in_valid        <= 1'b1;
          in_rx_byte      <= next_item.rx;
          in_end_of_burst <= next_item.eob;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted CRSF byte with the oldest expectation, then
  // choose the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (crsf_q.size() == 0) begin
        flag_mismatch("unexpected byte", '{data: 8'h00, frame_end: 1'b0, last: 1'b0},
                      '{data: out_tx_byte, frame_end: out_frame_end, last: out_last});
      end else begin
        want = crsf_q.pop_front();
        if (out_tx_byte !== want.data || out_frame_end !== want.frame_end ||
            out_last !== want.last)
          flag_mismatch("wrong field", want,
                        '{data: out_tx_byte, frame_end: out_frame_end, last: out_last});
      end
    end
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  // Hold-off timer: once requested, keep the receiver off until the timer runs out.
  always @(negedge clk) begin
    if (hold_go && hold_cnt < HoldOffCycles) begin
      hold_off = 1'b1;
      hold_cnt = hold_cnt + 1;
    end else begin
      hold_off = 1'b0;
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Block until every queued byte went in and every expected byte came out.
  task automatic wait_drained();
    while (telem_q.size() != 0 || in_valid || crsf_q.size() != 0) @(negedge clk);
  endtask

  // Stimulus: all shared state is touched at the falling edge only.
  initial begin
    for (int i = 0; i < etcf_pkg::StoreDepth; i++) telem_store[i] = 8'h00;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Directed: a lone flagged byte frames the all-zero store right after reset.
    telem_q.push_back('{rx: 8'h5A, eob: 1'b1});
    // Full burst of all ones, flag on position 16: maximal fields, temperature 2550.
    for (int i = 0; i <= 16; i++) telem_q.push_back('{rx: 8'hFF, eob: (i == 16)});
    // Short burst: only position 3 is overwritten with zero, the rest keep 0xFF.
    for (int i = 0; i < 4; i++) telem_q.push_back('{rx: 8'h00, eob: (i == 3)});
    wait_drained();

    // Random phases: no idling, idle sender, stalling receiver, then both a little.
    add_bursts(40);
    wait_drained();
    idle_pct = 85;
    add_bursts(40);
    wait_drained();
    idle_pct = 0;
    stall_pct = 85;
    add_bursts(40);
    wait_drained();
    idle_pct = 15;
    stall_pct = 15;
    add_bursts(40);
    wait_drained();

    // Back-pressure: hold the receiver off while the sender keeps offering bytes,
    // so the output register fills and the input stalls behind it.
    idle_pct = 0;
    stall_pct = 0;
    hold_go = 1'b1;
    add_bursts(40);
    wait (hold_cnt == HoldOffCycles);
    hold_go = 1'b0;
    wait_drained();

    repeat (DrainCycles) @(negedge clk);
    if (crsf_q.size() != 0) begin
      mismatches += crsf_q.size();
      $display("mismatch: %0d expected bytes never arrived", crsf_q.size());
    end
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
